// ----- hw/rtl/evpl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the encoder velocity PID loop.
// Depends on nothing; every other file of the block imports it.
package evpl_pkg;

  // Field widths of the transfers and the configuration port.
  localparam int unsigned ENC_W      = 32;
  localparam int unsigned TGT_W      = 24;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned MAG_W      = 10;
  localparam int unsigned FVEL_W     = 24;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned WEIGHT_W   = 17;
  localparam int unsigned RATE_W     = 17;

  // Shared multiplier: signed A by unsigned B.
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W + 1;

  // Internal arithmetic widths.
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned POS_W   = 48;
  localparam int unsigned WHOLE_W = 32;
  localparam int unsigned DIFF_W  = 33;
  localparam int unsigned RAW_W   = 24;
  localparam int unsigned VEL_W   = 40;
  localparam int unsigned ERR_W   = 25;
  localparam int unsigned EDIF_W  = 26;
  localparam int unsigned ESUM_W  = 48;
  localparam int unsigned IACC_W  = 73;
  localparam int unsigned ITRM_W  = 61;
  localparam int unsigned DUTY_W  = 34;
  localparam int unsigned FRAC_W  = 16;

  // Control constants.
  localparam int unsigned DUTY_LIMIT   = 1000;
  localparam int          INT_SUM_GATE = 2000;
  localparam int          DEADBAND     = 500;

  localparam logic signed [ACC_W-1:0] DUTY_LIM_Q16 =
    ACC_W'(DUTY_LIMIT) <<< FRAC_W;
  localparam logic [IACC_W-1:0] ITERM_LIM = IACC_W'(1) << 60;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 4'd0,
    REG_INTEG_GAIN  = 4'd1,
    REG_DERIV_GAIN  = 4'd2,
    REG_POS_NEW_W   = 4'd3,
    REG_POS_OLD_W   = 4'd4,
    REG_VEL_NEW_W   = 4'd5,
    REG_VEL_OLD_W   = 4'd6,
    REG_TICK_RATE   = 4'd7
  } cfg_idx_e;

  // Drive direction codes.
  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } drive_dir_e;

  // Saturate a wide signed value to 48 bits.
  function automatic logic signed [47:0] sat48(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (ACC_W'(1) <<< 47) - ACC_W'(1);
    lo = -hi - ACC_W'(1);
    if (x > hi) return hi[47:0];
    if (x < lo) return lo[47:0];
    return x[47:0];
  endfunction

  // Saturate a wide signed value to 40 bits.
  function automatic logic signed [39:0] sat40(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (ACC_W'(1) <<< 39) - ACC_W'(1);
    lo = -hi - ACC_W'(1);
    if (x > hi) return hi[39:0];
    if (x < lo) return lo[39:0];
    return x[39:0];
  endfunction

  // Saturate a wide signed value to 24 bits.
  function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (ACC_W'(1) <<< 23) - ACC_W'(1);
    lo = -hi - ACC_W'(1);
    if (x > hi) return hi[23:0];
    if (x < lo) return lo[23:0];
    return x[23:0];
  endfunction

endpackage

// ----- hw/rtl/evpl_in_if.sv -----
`timescale 1ns / 1ps
// Input channel of the encoder velocity PID loop: one sample tick per transfer.
// Depends on evpl_pkg for the field widths.
interface evpl_in_if
  import evpl_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [ENC_W-1:0] encoder_count;
  logic signed [TGT_W-1:0] target_velocity;

  modport source (output valid, output encoder_count, output target_velocity, input ready);
  modport sink   (input valid, input encoder_count, input target_velocity, output ready);
endinterface

// ----- hw/rtl/evpl_out_if.sv -----
`timescale 1ns / 1ps
// Output channel of the encoder velocity PID loop: one drive command per transfer.
// Depends on evpl_pkg for the field widths.
interface evpl_out_if
  import evpl_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [DIR_W-1:0]         drive_direction;
  logic [MAG_W-1:0]         duty_magnitude;
  logic signed [FVEL_W-1:0] filtered_velocity;

  modport source (output valid, output drive_direction, output duty_magnitude,
                  output filtered_velocity, input ready);
  modport sink   (input valid, input drive_direction, input duty_magnitude,
                  input filtered_velocity, output ready);
endinterface

// ----- hw/rtl/encoder_velocity_pid_loop_top.sv -----
`timescale 1ns / 1ps
// Top level of the encoder velocity PID loop: sequencer, datapath and registers.
// Depends on evpl_pkg, evpl_in_if, evpl_out_if and evpl_mul.

// Velocity PID loop on encoder samples. Each input transfer is one sample tick; it
// produces exactly one output transfer with the drive direction, the duty magnitude
// and the filtered velocity. A tick is worked through by a small sequencer around a
// single registered multiplier (34 x 24 bits) and one 64-bit accumulator, so the
// input is ready only while the sequencer is idle: a new tick is accepted only once
// the multiply and accumulate sequence of the last one is through. A finished
// result sits in the output register while the next tick is already being worked
// on; only if the previous result has still not been taken when the next one is
// ready does the sequencer hold. Configuration writes take effect at once and are
// meant to be made while no tick is in flight.
module encoder_velocity_pid_loop_top
  import evpl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  evpl_in_if.sink               in_i,
  evpl_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_M_ENC, ST_M_PH, ST_M_PL, ST_POS_ACC, ST_POS_SAT,
    ST_WHOLE, ST_DIFF, ST_M_RAW, ST_RAW_SAT,
    ST_M_VN, ST_M_VH, ST_M_VL, ST_VEL_ACC, ST_VEL_SAT,
    ST_ERR, ST_SUM, ST_M_P, ST_M_D, ST_M_IH, ST_M_IL,
    ST_I_ACC, ST_I_SAT, ST_I_ADD, ST_DUTY, ST_FIN
  } state_e;

  // Configuration registers.
  logic [GAIN_W-1:0]   kp_q, ki_q, kd_q;
  logic [WEIGHT_W-1:0] pos_new_w_q, pos_old_w_q, vel_new_w_q, vel_old_w_q;
  logic [RATE_W-1:0]   tick_rate_q;

  // Sequencer, loop state and working registers.
  state_e                     state_q;
  logic signed [ENC_W-1:0]    enc_q;
  logic signed [TGT_W-1:0]    tgt_q;
  logic signed [POS_W-1:0]    pos_q;
  logic signed [WHOLE_W-1:0]  whole_q;
  logic signed [WHOLE_W-1:0]  prev_whole_q;
  logic signed [DIFF_W-1:0]   diff_q;
  logic signed [RAW_W-1:0]    raw_q;
  logic signed [VEL_W-1:0]    vel_q;
  logic signed [ERR_W-1:0]    err_q;
  logic signed [ERR_W-1:0]    prev_err_q;
  logic signed [EDIF_W-1:0]   ediff_q;
  logic signed [ESUM_W-1:0]   esum_q;
  logic        [ESUM_W-1:0]   esum_abs_q;
  logic                       esum_neg_q;
  logic        [IACC_W-1:0]   iacc_q;
  logic        [ITRM_W-1:0]   iterm_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [DUTY_W-1:0]   duty_q;

  // Output register.
  logic                       out_valid_q;
  logic [DIR_W-1:0]           dir_q;
  logic [MAG_W-1:0]           mag_q;
  logic signed [FVEL_W-1:0]   fvel_q;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0]  mul_a;
  logic        [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]    prod;

  // Intermediate values.
  logic signed [WHOLE_W-1:0]  whole_c;
  logic signed [ACC_W-1:0]    esum_sum;
  logic                       sum_gate;
  logic signed [ACC_W-1:0]    iterm_ext;
  logic signed [DUTY_W-1:0]   duty_abs;
  logic                       out_free;

  evpl_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign prod = ACC_W'(mul_p);

  // Operand selection for the multiply issued in each step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_M_ENC: begin
        mul_a = MUL_A_W'(enc_q);
        mul_b = MUL_B_W'(pos_new_w_q);
      end
      ST_M_PH: begin
        mul_a = MUL_A_W'($signed(pos_q[POS_W-1:FRAC_W]));
        mul_b = MUL_B_W'(pos_old_w_q);
      end
      ST_M_PL: begin
        mul_a = MUL_A_W'({1'b0, pos_q[FRAC_W-1:0]});
        mul_b = MUL_B_W'(pos_old_w_q);
      end
      ST_M_RAW: begin
        mul_a = MUL_A_W'(diff_q);
        mul_b = MUL_B_W'(tick_rate_q);
      end
      ST_M_VN: begin
        mul_a = MUL_A_W'(raw_q);
        mul_b = MUL_B_W'(vel_new_w_q);
      end
      ST_M_VH: begin
        mul_a = MUL_A_W'($signed(vel_q[VEL_W-1:FRAC_W]));
        mul_b = MUL_B_W'(vel_old_w_q);
      end
      ST_M_VL: begin
        mul_a = MUL_A_W'({1'b0, vel_q[FRAC_W-1:0]});
        mul_b = MUL_B_W'(vel_old_w_q);
      end
      ST_M_P: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = kp_q;
      end
      ST_M_D: begin
        mul_a = MUL_A_W'(ediff_q);
        mul_b = kd_q;
      end
      ST_M_IH: begin
        mul_a = MUL_A_W'({1'b0, esum_abs_q[ESUM_W-1:GAIN_W]});
        mul_b = ki_q;
      end
      ST_M_IL: begin
        mul_a = MUL_A_W'({1'b0, esum_abs_q[GAIN_W-1:0]});
        mul_b = ki_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Whole position truncated toward zero: floor plus one for a negative fraction.
  assign whole_c = pos_q[POS_W-1:FRAC_W]
                 + WHOLE_W'(pos_q[POS_W-1] & (|pos_q[FRAC_W-1:0]));

  // Error sum grows only outside the gate band.
  assign sum_gate = (err_q > ERR_W'(INT_SUM_GATE)) || (err_q < -ERR_W'(INT_SUM_GATE));
  assign esum_sum = ACC_W'(esum_q) + ACC_W'(err_q);

  // Integral term with the sign of the error sum restored.
  assign iterm_ext = esum_neg_q ? -ACC_W'({1'b0, iterm_q}) : ACC_W'({1'b0, iterm_q});

  assign duty_abs = duty_q[DUTY_W-1] ? -duty_q : duty_q;

  assign out_free = !out_valid_q || out_o.ready;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= GAIN_W'(6554);
      ki_q        <= '0;
      kd_q        <= '0;
      pos_new_w_q <= WEIGHT_W'(6554);
      pos_old_w_q <= WEIGHT_W'(58982);
      vel_new_w_q <= WEIGHT_W'(6554);
      vel_old_w_q <= WEIGHT_W'(58982);
      tick_rate_q <= RATE_W'(1000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PROP_GAIN:  kp_q        <= cfg_data_i;
        REG_INTEG_GAIN: ki_q        <= cfg_data_i;
        REG_DERIV_GAIN: kd_q        <= cfg_data_i;
        REG_POS_NEW_W:  pos_new_w_q <= cfg_data_i[WEIGHT_W-1:0];
        REG_POS_OLD_W:  pos_old_w_q <= cfg_data_i[WEIGHT_W-1:0];
        REG_VEL_NEW_W:  vel_new_w_q <= cfg_data_i[WEIGHT_W-1:0];
        REG_VEL_OLD_W:  vel_old_w_q <= cfg_data_i[WEIGHT_W-1:0];
        REG_TICK_RATE:  tick_rate_q <= cfg_data_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer with the loop state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      enc_q        <= '0;
      tgt_q        <= '0;
      pos_q        <= '0;
      whole_q      <= '0;
      prev_whole_q <= '0;
      diff_q       <= '0;
      raw_q        <= '0;
      vel_q        <= '0;
      err_q        <= '0;
      prev_err_q   <= '0;
      ediff_q      <= '0;
      esum_q       <= '0;
      esum_abs_q   <= '0;
      esum_neg_q   <= 1'b0;
      iacc_q       <= '0;
      iterm_q      <= '0;
      acc_q        <= '0;
      duty_q       <= '0;
      out_valid_q  <= 1'b0;
      dir_q        <= DIR_STOP;
      mag_q        <= '0;
      fvel_q       <= '0;
    end else begin
      // The result leaves on a completed output transfer, unless the final step
      // replaces it with the next one in the same cycle.
      if (out_valid_q && out_o.ready && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            enc_q   <= in_i.encoder_count;
            tgt_q   <= in_i.target_velocity;
            state_q <= ST_M_ENC;
          end
        end

        // Position filter: enc*wn + old*wo/2^16, old split into whole and fraction.
        ST_M_ENC:   state_q <= ST_M_PH;
        ST_M_PH: begin
          acc_q   <= prod;
          state_q <= ST_M_PL;
        end
        ST_M_PL: begin
          acc_q   <= acc_q + prod;
          state_q <= ST_POS_ACC;
        end
        ST_POS_ACC: begin
          acc_q   <= acc_q + (prod >>> FRAC_W);
          state_q <= ST_POS_SAT;
        end
        ST_POS_SAT: begin
          pos_q   <= sat48(acc_q);
          state_q <= ST_WHOLE;
        end

        // Raw velocity from the change of whole position.
        ST_WHOLE: begin
          whole_q <= whole_c;
          state_q <= ST_DIFF;
        end
        ST_DIFF: begin
          diff_q       <= DIFF_W'(whole_q) - DIFF_W'(prev_whole_q);
          prev_whole_q <= whole_q;
          state_q      <= ST_M_RAW;
        end
        ST_M_RAW:   state_q <= ST_RAW_SAT;
        ST_RAW_SAT: begin
          raw_q   <= sat24(prod);
          state_q <= ST_M_VN;
        end

        // Velocity filter, same form as the position filter.
        ST_M_VN:    state_q <= ST_M_VH;
        ST_M_VH: begin
          acc_q   <= prod;
          state_q <= ST_M_VL;
        end
        ST_M_VL: begin
          acc_q   <= acc_q + prod;
          state_q <= ST_VEL_ACC;
        end
        ST_VEL_ACC: begin
          acc_q   <= acc_q + (prod >>> FRAC_W);
          state_q <= ST_VEL_SAT;
        end
        ST_VEL_SAT: begin
          vel_q   <= sat40(acc_q);
          state_q <= ST_ERR;
        end

        // Error, error sum and error difference.
        ST_ERR: begin
          err_q   <= ERR_W'(tgt_q) - ERR_W'($signed(vel_q[VEL_W-1:FRAC_W]));
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          esum_q     <= sum_gate ? sat48(esum_sum) : '0;
          ediff_q    <= EDIF_W'(err_q) - EDIF_W'(prev_err_q);
          prev_err_q <= err_q;
          state_q    <= ST_M_P;
        end

        // PID products: P, then D, then the integral in two halves.
        ST_M_P: begin
          esum_neg_q <= esum_q[ESUM_W-1];
          esum_abs_q <= esum_q[ESUM_W-1] ? ESUM_W'(-esum_q) : ESUM_W'(esum_q);
          state_q    <= ST_M_D;
        end
        ST_M_D: begin
          acc_q   <= prod;
          state_q <= ST_M_IH;
        end
        ST_M_IH: begin
          acc_q   <= acc_q + prod;
          state_q <= ST_M_IL;
        end
        ST_M_IL: begin
          iacc_q  <= {1'b0, mul_p[ESUM_W-1:0], {GAIN_W{1'b0}}};
          state_q <= ST_I_ACC;
        end
        ST_I_ACC: begin
          iacc_q  <= iacc_q + IACC_W'(mul_p[ESUM_W-1:0]);
          state_q <= ST_I_SAT;
        end
        ST_I_SAT: begin
          iterm_q <= (iacc_q > ITERM_LIM) ? ITRM_W'(ITERM_LIM) : iacc_q[ITRM_W-1:0];
          state_q <= ST_I_ADD;
        end
        ST_I_ADD: begin
          acc_q   <= acc_q + iterm_ext;
          state_q <= ST_DUTY;
        end

        // Clamp, then the deadband forces the duty to zero.
        ST_DUTY: begin
          if ((err_q <= ERR_W'(DEADBAND)) && (err_q >= -ERR_W'(DEADBAND))) begin
            duty_q <= '0;
          end else if (acc_q > DUTY_LIM_Q16) begin
            duty_q <= DUTY_W'(DUTY_LIM_Q16);
          end else if (acc_q < -DUTY_LIM_Q16) begin
            duty_q <= DUTY_W'(-DUTY_LIM_Q16);
          end else begin
            duty_q <= acc_q[DUTY_W-1:0];
          end
          state_q <= ST_FIN;
        end

        // Load the output register once the previous result has gone.
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            fvel_q      <= vel_q[VEL_W-1:FRAC_W];
            mag_q       <= duty_abs[FRAC_W+MAG_W-1:FRAC_W];
            if (duty_q[DUTY_W-1]) begin
              dir_q <= DIR_REV;
            end else if (duty_q != '0) begin
              dir_q <= DIR_FWD;
            end else begin
              dir_q <= DIR_STOP;
            end
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready              = (state_q == ST_IDLE);
  assign out_o.valid             = out_valid_q;
  assign out_o.drive_direction   = dir_q;
  assign out_o.duty_magnitude    = mag_q;
  assign out_o.filtered_velocity = fvel_q;

endmodule

// ----- hw/rtl/evpl_mul.sv -----
`timescale 1ns / 1ps
// Shared registered multiplier: signed operand A times unsigned operand B.
// Depends on evpl_pkg for the operand widths.
module evpl_mul
  import evpl_pkg::*;
(
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic        [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_d;
  logic signed [MUL_P_W-1:0] p_q;

  // B is zero-extended so that the product is a plain signed multiply.
  assign p_d = MUL_P_W'(a_i) * $signed({1'b0, b_i});

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ----- sim/encoder_velocity_pid_loop_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for encoder_velocity_pid_loop_top: sample ticks in, drive commands out.
// Depends on evpl_pkg, evpl_in_if, evpl_out_if and the RTL of the block; nothing else.
module encoder_velocity_pid_loop_top_tb;
  import evpl_pkg::*;

  localparam int unsigned NUM_CFG_REGS    = 8;
  localparam int unsigned NUM_PRESETS     = 7;
  localparam int unsigned NUM_PHASES      = 12;
  localparam int unsigned PHASE_ITEMS     = 54;
  localparam int unsigned DIRECTED_N      = 21;
  localparam int unsigned PRESSURE_PHASE  = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 500;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned REPORT_LIMIT    = 10;

  // Register indexes beyond the implemented set; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 4'd15;

  localparam longint ITERM_CAP = longint'(ITERM_LIM);

  typedef struct packed {
    drive_dir_e               dir;
    logic [MAG_W-1:0]         magnitude;
    logic signed [FVEL_W-1:0] velocity;
  } drive_cmd_t;

  typedef struct packed {
    logic signed [ENC_W-1:0] enc;
    logic signed [TGT_W-1:0] tgt;
    logic                    pinned;
    drive_cmd_t              cmd;
  } tick_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  evpl_in_if  in_if ();
  evpl_out_if out_if ();

  encoder_velocity_pid_loop_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Register copy and loop state of the predictor.
  logic [CFG_DATA_W-1:0] cfg_shadow [NUM_CFG_REGS];
  longint est_position  = 0;
  longint last_whole    = 0;
  longint est_velocity  = 0;
  longint err_accum     = 0;
  longint last_err      = 0;

  drive_cmd_t  expected_drive_q [$];
  int unsigned ticks_sent    = 0;
  int unsigned cmds_checked  = 0;
  int unsigned fault_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned settings_used = 0;
  int unsigned idle_pct      = 0;
  logic        hold_off_req  = 1'b0;

  // Order of every row: Kp, Ki*Ts, Kd/Ts, position weights new/old,
  // velocity weights new/old, tick rate.
  logic [CFG_DATA_W-1:0] presets [NUM_PRESETS][NUM_CFG_REGS] = '{
    '{24'd6554,   24'd0,      24'd0,      24'd6554,   24'd58982,  24'd6554,  24'd58982,
      24'd1000},
    '{24'd1,      24'd0,      24'd0,      24'd6554,   24'd58982,  24'd6554,  24'd58982,
      24'd0},
    '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h1FFFF,  24'h1FFFF, 24'h1FFFF,
      24'd100000},
    '{24'd0,      24'd0,      24'd0,      24'd0,      24'd0,      24'd0,     24'd0,
      24'd1},
    '{24'd65536,  24'd6554,   24'd3277,   24'd32768,  24'd32768,  24'd16384, 24'd49152,
      24'd1000},
    '{24'd655360, 24'd65536,  24'd65536,  24'd65536,  24'd0,      24'd65536, 24'd0,
      24'd100},
    '{24'd6554,   24'd1000,   24'd200000, 24'd13107,  24'd52429,  24'd6554,  24'd58982,
      24'd2000}
  };

  // Directed ticks from reset; only the first few have an obvious answer.
  tick_row_t directed_rows [DIRECTED_N] = '{
    '{32'sd0,          24'sd0,        1'b1, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sd0,          24'sh7FFFFF,   1'b1, '{DIR_FWD,  10'd1000, 24'sd0}},
    '{32'sd0,          24'sh800000,   1'b1, '{DIR_REV,  10'd1000, 24'sd0}},
    '{32'sd0,          24'sd500,      1'b1, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sd0,          -24'sd500,     1'b1, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sd0,          24'sd501,      1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sd0,          -24'sd501,     1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sd0,          24'sd2000,     1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sd0,          24'sd2001,     1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sd0,          -24'sd2001,    1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sh7FFFFFFF,   24'sd0,        1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sh80000000,   24'sd0,        1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sh80000000,   24'sh7FFFFF,   1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sh7FFFFFFF,   24'sh800000,   1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sd100,        24'sd0,        1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sd200,        24'sd100000,   1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sd300,        24'sd100000,   1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sd400,        24'sd100000,   1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sd500,        24'sd100000,   1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sd600,        -24'sd100000,  1'b0, '{DIR_STOP, 10'd0,    24'sd0}},
    '{32'sd0,          24'sd0,        1'b0, '{DIR_STOP, 10'd0,    24'sd0}}
  };

  // Clock and cycle guard.
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_drive_q.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint saturate(input longint x, input int unsigned bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic longint reg_val(input cfg_idx_e r);
    return longint'({40'd0, cfg_shadow[r]});
  endfunction

  // Gains are 24 bits wide, weights and the tick rate 17; other indexes do nothing.
  function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    if (idx <= REG_DERIV_GAIN)
      cfg_shadow[idx] = data;
    else if (idx <= REG_TICK_RATE)
      cfg_shadow[idx] = data & CFG_DATA_W'((1 << WEIGHT_W) - 1);
  endfunction

  // One control tick: both filters, the gated error sum, PID, clamp and deadband.
  function automatic drive_cmd_t predict_drive(input logic signed [ENC_W-1:0] enc,
                                               input logic signed [TGT_W-1:0] tgt);
    drive_cmd_t cmd;
    longint     pos_hi;
    longint     pos_lo;
    longint     whole;
    longint     raw;
    longint     vel;
    longint     err;
    longint     iterm;
    longint     accum_mag;
    longint     duty;

    pos_hi = est_position >>> FRAC_W;
    pos_lo = est_position & 64'hFFFF;
    est_position = saturate(longint'(enc) * reg_val(REG_POS_NEW_W)
                            + pos_hi * reg_val(REG_POS_OLD_W)
                            + ((pos_lo * reg_val(REG_POS_OLD_W)) >>> FRAC_W), POS_W);

    // The whole position is truncated towards zero, not floored.
    if (est_position < 0)
      whole = -((-est_position) >>> FRAC_W);
    else
      whole = est_position >>> FRAC_W;
    raw = saturate((whole - last_whole) * reg_val(REG_TICK_RATE), RAW_W);
    last_whole = whole;

    est_velocity = saturate(raw * reg_val(REG_VEL_NEW_W)
                            + ((est_velocity * reg_val(REG_VEL_OLD_W)) >>> FRAC_W), VEL_W);
    vel = est_velocity >>> FRAC_W;

    // The error sum only runs while the error is outside the gate.
    err = longint'(tgt) - vel;
    if (err > INT_SUM_GATE || err < -INT_SUM_GATE)
      err_accum = saturate(err_accum + err, ESUM_W);
    else
      err_accum = 0;

    if (reg_val(REG_INTEG_GAIN) == 0 || err_accum == 0) begin
      iterm = 0;
    end else begin
      accum_mag = (err_accum < 0) ? -err_accum : err_accum;
      if (accum_mag > ITERM_CAP / reg_val(REG_INTEG_GAIN))
        iterm = (err_accum < 0) ? -ITERM_CAP : ITERM_CAP;
      else
        iterm = err_accum * reg_val(REG_INTEG_GAIN);
    end

    duty = err * reg_val(REG_PROP_GAIN) + iterm + (err - last_err) * reg_val(REG_DERIV_GAIN);
    last_err = err;

    if (duty > DUTY_LIM_Q16)
      duty = DUTY_LIM_Q16;
    else if (duty < -DUTY_LIM_Q16)
      duty = -DUTY_LIM_Q16;
    if (err <= DEADBAND && err >= -DEADBAND)
      duty = 0;

    if (duty > 0) begin
      cmd.dir       = DIR_FWD;
      cmd.magnitude = MAG_W'(duty >>> FRAC_W);
    end else if (duty < 0) begin
      cmd.dir       = DIR_REV;
      cmd.magnitude = MAG_W'((-duty) >>> FRAC_W);
    end else begin
      cmd.dir       = DIR_STOP;
      cmd.magnitude = '0;
    end
    cmd.velocity = FVEL_W'(vel);
    return cmd;
  endfunction

  // Offer one tick, wait for its transfer, then perhaps leave a gap.
  task automatic send_tick(input logic signed [ENC_W-1:0] enc,
                           input logic signed [TGT_W-1:0] tgt,
                           input logic pinned, input drive_cmd_t pinned_cmd);
    drive_cmd_t cmd;
    in_if.valid           <= 1'b1;
    in_if.encoder_count   <= enc;
    in_if.target_velocity <= tgt;
    do begin
      @(posedge clk_i);
    end while (!in_if.ready);
    cmd = predict_drive(enc, tgt);
    expected_drive_q.push_back(pinned ? pinned_cmd : cmd);
    ticks_sent++;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every expected command has been taken.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    store_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] vals [NUM_CFG_REGS],
                               input logic with_spare);
    if (with_spare) begin
      write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
      write_reg(CFG_IDX_TOP, CFG_DATA_W'($urandom));
    end
    for (int r = 0; r < NUM_CFG_REGS; r++)
      write_reg(CFG_IDX_W'(r), vals[r]);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Result side: random stall bursts, and one long hold-off on request.
  initial begin : result_sink
    logic hold_off_done;
    hold_off_done = 1'b0;
    out_if.ready  = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Every drive command transfer is compared with the oldest expectation.
  always @(posedge clk_i) begin : drive_monitor
    drive_cmd_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_drive_q.size() == 0) begin
        if (fault_count < REPORT_LIMIT)
          $display("unexpected command: dir %0d mag %0d vel %0d", out_if.drive_direction,
                   out_if.duty_magnitude, out_if.filtered_velocity);
        fault_count++;
      end else begin
        want = expected_drive_q.pop_front();
        cmds_checked++;
        if (out_if.drive_direction !== want.dir || out_if.duty_magnitude !== want.magnitude
            || out_if.filtered_velocity !== want.velocity) begin
          if (fault_count < REPORT_LIMIT)
            $display("command %0d: expected dir %0d mag %0d vel %0d, got dir %0d mag %0d vel %0d",
                     cmds_checked, want.dir, want.magnitude, want.velocity,
                     out_if.drive_direction, out_if.duty_magnitude, out_if.filtered_velocity);
          fault_count++;
        end
      end
    end
  end

  // Stimulus: reset, directed ticks, then one random phase per register setting.
  initial begin : stimulus
    logic [CFG_DATA_W-1:0]   vals [NUM_CFG_REGS];
    logic signed [ENC_W-1:0] enc;
    logic signed [TGT_W-1:0] tgt;
    int                      enc_track;
    int                      step;
    int                      offset;
    int unsigned             pick;
    int unsigned             weight;
    longint                  tgt_base;

    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = '0;
    cfg_data_i            = '0;
    in_if.valid           = 1'b0;
    in_if.encoder_count   = '0;
    in_if.target_velocity = '0;
    cfg_shadow            = presets[0];
    enc_track             = 0;
    step                  = 0;
    tgt_base              = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    for (int i = 0; i < DIRECTED_N; i++)
      send_tick(directed_rows[i].enc, directed_rows[i].tgt, directed_rows[i].pinned,
                directed_rows[i].cmd);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      if (phase == NUM_PHASES - 1) begin
        idle_pct = 0;
        vals     = presets[4];
      end else if (phase < NUM_PRESETS) begin
        idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 10 : 30);
        vals     = presets[phase];
      end else begin
        idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 10 : 30);
        vals[REG_PROP_GAIN]  = CFG_DATA_W'($urandom_range(0, 1 << 18));
        vals[REG_INTEG_GAIN] = CFG_DATA_W'($urandom_range(0, 1 << 16));
        vals[REG_DERIV_GAIN] = CFG_DATA_W'($urandom_range(0, 1 << 18));
        weight               = $urandom_range(0, 65536);
        vals[REG_POS_NEW_W]  = CFG_DATA_W'(weight);
        vals[REG_POS_OLD_W]  = CFG_DATA_W'(65536 - weight);
        weight               = $urandom_range(0, 65536);
        vals[REG_VEL_NEW_W]  = CFG_DATA_W'(weight);
        vals[REG_VEL_OLD_W]  = CFG_DATA_W'(65536 - weight);
        vals[REG_TICK_RATE]  = CFG_DATA_W'($urandom_range(1, 100000));
      end
      apply_setting(vals, phase == 0 || phase >= NUM_PRESETS);
      if (phase == PRESSURE_PHASE)
        hold_off_req <= 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // A new steady speed and a target near it every so often.
        if (n % 18 == 0) begin
          step     = $urandom_range(0, 200);
          step     = step - 100;
          offset   = $urandom_range(0, 6000);
          offset   = offset - 3000;
          tgt_base = longint'(step) * reg_val(REG_TICK_RATE) + longint'(offset);
        end
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          offset    = $urandom_range(0, 4);
          enc_track = enc_track + step + offset - 2;
          enc       = enc_track;
          offset    = $urandom_range(0, 1200);
          tgt       = TGT_W'(saturate(tgt_base + longint'(offset) - 600, TGT_W));
        end else if (pick < 92) begin
          enc = $urandom;
          tgt = TGT_W'($urandom);
        end else begin
          enc_track = $urandom;
          enc       = enc_track;
          case ($urandom_range(0, 2))
            0:       tgt = 24'sh7FFFFF;
            1:       tgt = 24'sh800000;
            default: tgt = '0;
          endcase
        end
        send_tick(enc, tgt, 1'b0, '0);
      end
    end
    drain();

    $display("ran %0d sample ticks under %0d register settings, %0d drive commands compared",
             ticks_sent, settings_used, cmds_checked);
    $display("including a %0d-cycle result hold-off and writes to unused register indexes",
             HOLD_OFF_CYCLES);
    if (fault_count == 0 && expected_drive_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d faults, %0d commands never arrived", fault_count, expected_drive_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/evpl_pkg.sv
hw/rtl/evpl_in_if.sv
hw/rtl/evpl_out_if.sv
hw/rtl/evpl_mul.sv
hw/rtl/encoder_velocity_pid_loop_top.sv
sim/encoder_velocity_pid_loop_top_tb.sv
